FILE: src/ctfc_pkg.sv
package ctfc_pkg;

	// Fixed field widths
	localparam int KEY_BITS     = 80;
	localparam int TAG_OUT_BITS = 16;
	localparam int SLOT_BITS    = 4;
	localparam int CAP_BITS     = 5;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF    = 16;
	localparam int TAG_BITS_DEF = 16;

	// Capacity register value after reset
	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	// Operation codes
	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_GET   = 1'b1;

	// Request item
	typedef struct packed {
		logic        op;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [31:0] pixel;
		logic [15:0] new_tag;
	} ctfc_req_t;

	// Response item
	typedef struct packed {
		logic                    hit;
		logic [TAG_OUT_BITS-1:0] tag_out;
		logic [SLOT_BITS-1:0]    slot;
	} ctfc_rsp_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} ctfc_state_t;

endpackage

FILE: src/ctfc_ram.sv
module ctfc_ram
	import ctfc_pkg::*;
#(
	parameter int WIDTH = KEY_BITS + TAG_BITS_DEF,
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/color_tag_fifo_cache.sv
// Fully associative key-to-tag table with FIFO replacement, one item at a time.
// Each item scans the filled entries in order and stops at the first key match; a get
// that misses then stores its key and new tag. The table is scanned one entry per cycle
// through the single read port of the entry memory, and a finished result waits while
// rsp_stall holds the previous one; a new item is taken only in the idle state.
// Reset: control, fill count and last-written slot clear, capacity returns to 16;
// memory contents stay undefined and are never read before being written.
module color_tag_fifo_cache
	import ctfc_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ctfc_req_t           req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ctfc_rsp_t           rsp,
	input  logic                cfg_we,
	input  logic [CAP_BITS-1:0] cfg_wdata
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = (TAG_BITS > TAG_OUT_BITS) ? TAG_BITS : TAG_OUT_BITS;
	localparam int SW = (IW > SLOT_BITS) ? IW : SLOT_BITS;
	localparam int MW = (CW > CAP_BITS) ? CW : CAP_BITS;
	localparam int EW = KEY_BITS + TAG_BITS;

	ctfc_state_t state_q, state_nxt;

	logic [KEY_BITS-1:0] key_q;
	logic                op_q;
	logic [TAG_BITS-1:0] ntag_q;
	logic [CW-1:0]       ptr_q;
	logic                pend_s1;
	logic [IW-1:0]       idx_s1;
	logic                hit_q;
	logic [TAG_BITS-1:0] found_tag_q;
	logic [IW-1:0]       found_idx_q;
	logic [CW-1:0]       fill_q;
	logic [IW-1:0]       last_q;
	logic [CAP_BITS-1:0] cap_q;
	logic                rsp_valid_q;
	ctfc_rsp_t           rsp_q;

	logic                rd_en;
	logic                fin_load;
	logic                wr_en;
	logic [EW-1:0]       rd_data;
	logic [KEY_BITS-1:0] rd_key;
	logic [TAG_BITS-1:0] rd_tag;
	logic                key_match;
	logic [MW-1:0]       cap_ext;
	logic [CW-1:0]       cap_live;
	logic [CW-1:0]       next_lw;
	logic [IW-1:0]       ins_idx;
	logic [CW-1:0]       fill_nxt;
	ctfc_rsp_t           rsp_nxt;

	// Entry memory: key in the upper bits, tag below
	ctfc_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ins_idx),
		.wdata({key_q, ntag_q}),
		.re   (rd_en),
		.raddr(ptr_q[IW-1:0]),
		.rdata(rd_data)
	);

	assign rd_key    = rd_data[EW-1:TAG_BITS];
	assign rd_tag    = rd_data[TAG_BITS-1:0];
	assign key_match = (rd_key == key_q);

	// Effective capacity: zero acts as one, saturate at DEPTH
	always_comb begin
		cap_ext = MW'(cap_q);
		if (cap_q == '0) begin
			cap_live = CW'(1);
		end else if (cap_ext > MW'(DEPTH)) begin
			cap_live = CW'(DEPTH);
		end else begin
			cap_live = CW'(cap_ext);
		end
	end

	// Insert slot: fill in order, then wrap after last written
	always_comb begin
		next_lw = CW'(last_q) + CW'(1);
		if (fill_q < cap_live) begin
			ins_idx  = fill_q[IW-1:0];
			fill_nxt = fill_q + CW'(1);
		end else begin
			ins_idx  = (next_lw >= cap_live) ? '0 : next_lw[IW-1:0];
			fill_nxt = cap_live;
		end
	end

	// Result item
	always_comb begin
		if (hit_q) begin
			rsp_nxt.hit     = 1'b1;
			rsp_nxt.tag_out = TAG_OUT_BITS'(TW'(found_tag_q));
			rsp_nxt.slot    = SLOT_BITS'(SW'(found_idx_q));
		end else if (op_q == OP_GET) begin
			rsp_nxt.hit     = 1'b0;
			rsp_nxt.tag_out = TAG_OUT_BITS'(TW'(ntag_q));
			rsp_nxt.slot    = SLOT_BITS'(SW'(ins_idx));
		end else begin
			rsp_nxt = '0;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (pend_s1 && key_match) begin
					state_nxt = ST_FIN;
				end else if (ptr_q == fill_q && !pend_s1) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		fin_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_SCAN: rd_en = (ptr_q < fill_q) && !(pend_s1 && key_match);
			ST_FIN:  fin_load = !rsp_valid_q || !rsp_stall;
			default: req_stall = 1'b1;
		endcase
	end

	// Store on a get that misses; no read is in flight in FIN
	assign wr_en = fin_load && !hit_q && (op_q == OP_GET);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			fill_q      <= '0;
			last_q      <= '0;
			cap_q       <= CAP_RESET;
			rsp_valid_q <= 1'b0;
			ptr_q       <= '0;
		end else begin
			state_q <= state_nxt;
			pend_s1 <= rd_en;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (req_valid && !req_stall) begin
				hit_q <= 1'b0;
				ptr_q <= '0;
			end else if (rd_en) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (state_q == ST_SCAN && pend_s1 && key_match) begin
				hit_q <= 1'b1;
			end
			if (wr_en) begin
				fill_q <= fill_nxt;
				last_q <= ins_idx;
			end
			if (fin_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			key_q  <= {req.red, req.green, req.blue, req.pixel};
			op_q   <= req.op;
			ntag_q <= TAG_BITS'(TW'(req.new_tag));
		end
		if (rd_en) begin
			idx_s1 <= ptr_q[IW-1:0];
		end
		if (state_q == ST_SCAN && pend_s1 && key_match) begin
			found_tag_q <= rd_tag;
			found_idx_q <= idx_s1;
		end
		if (fin_load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
